// ===== design/ebcpu_pkg.sv =====
// Package for the eight-bit CPU subset core: item structs, opcode codes, flag positions
// and the memory geometry. Used by eight_bit_cpu_subset_core; depends on nothing.
package ebcpu_pkg;

	localparam int ADDR_BITS = 16;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	typedef logic [ADDR_BITS-1:0] mem_addr_t;

	// Flag bit positions within the 4-bit flag register.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// Opcodes.
	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_LD_BC   = 8'h01;
	localparam logic [7:0] OP_LD_DE   = 8'h11;
	localparam logic [7:0] OP_LD_HL   = 8'h21;
	localparam logic [7:0] OP_LD_SP   = 8'h31;
	localparam logic [7:0] OP_ST_BC   = 8'h02;
	localparam logic [7:0] OP_ST_DE   = 8'h12;
	localparam logic [7:0] OP_ST_HLI  = 8'h22;
	localparam logic [7:0] OP_ST_HLD  = 8'h32;
	localparam logic [7:0] OP_PREFIX  = 8'hcb;
	localparam logic [4:0] GRP_ADC    = 5'b10001;
	localparam logic [4:0] GRP_XOR    = 5'b10101;
	localparam logic [1:0] GRP_BIT    = 2'b01;

	// Register select codes of the low three opcode bits.
	localparam logic [2:0] SEL_B  = 3'd0;
	localparam logic [2:0] SEL_C  = 3'd1;
	localparam logic [2:0] SEL_D  = 3'd2;
	localparam logic [2:0] SEL_E  = 3'd3;
	localparam logic [2:0] SEL_H  = 3'd4;
	localparam logic [2:0] SEL_L  = 3'd5;
	localparam logic [2:0] SEL_HL = 3'd6;
	localparam logic [2:0] SEL_A  = 3'd7;

	typedef struct packed {
		logic        mode;
		logic [15:0] load_address;
		logic [7:0]  load_data;
	} req_item_t;

	typedef struct packed {
		logic [15:0] pc_out;
		logic [7:0]  acc_out;
		logic [3:0]  flags_out;
		logic [15:0] bc_out;
		logic [15:0] de_out;
		logic [15:0] hl_out;
		logic [15:0] sp_out;
		logic [1:0]  step_cycles;
		logic [31:0] cycles_total;
		logic        halted_out;
		logic [7:0]  opcode_seen;
	} rsp_item_t;

endpackage

// ===== design/eight_bit_cpu_subset_core.sv =====
// Top level of the eight-bit CPU subset core: sequencer, register file and program memory.
// Depends on ebcpu_pkg.
//
// Usage: each item on the req channel either writes one byte into the internal 64 KiB
// memory (mode 1, used to load the program) or executes the single instruction at the
// program counter (mode 0). Every item produces exactly one item on the rsp channel
// carrying the full register state after it, the machine cycles of the instruction and
// the running cycle total.
// The result is registered in the finishing state: S_LOAD for memory writes, S_HALT for
// halted steps, S_OP for NOP, ADC, XOR, stores and unknown opcodes, S_CB after S_OP for
// BIT, and S_IMM2 after S_OP and S_IMM1 for 16-bit immediate loads.
// An item occupies the accept state plus its sequencer states; no new item is taken
// before idle. The single memory read port sets these states: opcode, then prefix or
// immediate bytes are read one per cycle; the next opcode is read at the next accept.
// The output register decouples the sides: while a result waits, the next item is taken
// and worked on; a stalled receiver holds the core only at the point where a further
// result has to be written.
// Reset clears all CPU registers, the program counter and halted flag; memory contents
// stay undefined until written. After an unknown opcode the core is halted and mode 0
// items return the unchanged state.
module eight_bit_cpu_subset_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  ebcpu_pkg::req_item_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output ebcpu_pkg::rsp_item_t  rsp
);
	import ebcpu_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_HALT = 3'd2;
	localparam logic [2:0] S_OP   = 3'd3;
	localparam logic [2:0] S_IMM1 = 3'd4;
	localparam logic [2:0] S_IMM2 = 3'd5;
	localparam logic [2:0] S_CB   = 3'd6;

	logic [2:0]  state_q, nxt_state;
	logic [15:0] pc_q, sp_q;
	logic [7:0]  acc_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [3:0]  flags_q;
	logic [31:0] cyc_q;
	logic        halted_q;

	logic [15:0] ld_addr_q;
	logic [7:0]  ld_data_q;
	logic [7:0]  op_q;
	logic [7:0]  lo_q;
	logic [7:0]  rdata_q;
	logic        rsp_valid_q;
	rsp_item_t   rsp_q;

	logic [7:0]  mem [0:MEM_DEPTH-1];

	logic [15:0] nxt_pc, nxt_sp;
	logic [7:0]  nxt_acc, nxt_b, nxt_c, nxt_d, nxt_e, nxt_h, nxt_l;
	logic [3:0]  nxt_flags;
	logic        nxt_halted;
	logic [1:0]  step;
	logic [7:0]  seen;
	logic        finishing;
	logic        fin;
	logic        out_free;
	logic        rd_en;
	mem_addr_t   rd_addr;
	logic        wr_en;
	mem_addr_t   wr_addr;
	logic [7:0]  wr_data;

	logic [15:0] pc_p1, pc_p2, hl, bc, de;
	logic [7:0]  rval;
	logic [8:0]  sum9;
	logic [4:0]  half5;
	logic [7:0]  xor_res;

	function automatic logic [7:0] sel_reg(input logic [2:0] idx, input logic [7:0] rb,
			input logic [7:0] rc, input logic [7:0] rd, input logic [7:0] re,
			input logic [7:0] rh, input logic [7:0] rl, input logic [7:0] ra);
		logic [7:0] v;
		unique case (idx)
			SEL_B:   v = rb;
			SEL_C:   v = rc;
			SEL_D:   v = rd;
			SEL_E:   v = re;
			SEL_H:   v = rh;
			SEL_L:   v = rl;
			SEL_A:   v = ra;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign fin       = finishing && out_free;

	assign pc_p1   = pc_q + 16'd1;
	assign pc_p2   = pc_q + 16'd2;
	assign hl      = {h_q, l_q};
	assign bc      = {b_q, c_q};
	assign de      = {d_q, e_q};
	// In the opcode state the read data is the opcode, in the prefix state the sub-opcode;
	// both carry the register select in their low three bits.
	assign rval    = sel_reg(rdata_q[2:0], b_q, c_q, d_q, e_q, h_q, l_q, acc_q);
	assign sum9    = {1'b0, acc_q} + {1'b0, rval} + {8'h00, flags_q[FLAG_C]};
	assign half5   = {1'b0, acc_q[3:0]} + {1'b0, rval[3:0]} + {4'h0, flags_q[FLAG_C]};
	assign xor_res = acc_q ^ rval;

	always_comb begin
		nxt_state  = state_q;
		nxt_pc     = pc_q;
		nxt_sp     = sp_q;
		nxt_acc    = acc_q;
		nxt_b      = b_q;
		nxt_c      = c_q;
		nxt_d      = d_q;
		nxt_e      = e_q;
		nxt_h      = h_q;
		nxt_l      = l_q;
		nxt_flags  = flags_q;
		nxt_halted = halted_q;
		step       = 2'd0;
		seen       = 8'h00;
		finishing  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = pc_q[ADDR_BITS-1:0];
		wr_en      = 1'b0;
		wr_addr    = ld_addr_q[ADDR_BITS-1:0];
		wr_data    = ld_data_q;

		unique case (state_q)
			S_IDLE: begin
				// The opcode is read speculatively; a memory write item ignores it.
				rd_en = 1'b1;
				if (req_valid) begin
					if (req.mode) begin
						nxt_state = S_LOAD;
					end else if (halted_q) begin
						nxt_state = S_HALT;
					end else begin
						nxt_state = S_OP;
					end
				end
			end
			S_LOAD: begin
				finishing = 1'b1;
				wr_en     = fin;
			end
			S_HALT: begin
				finishing = 1'b1;
			end
			S_OP: begin
				seen = rdata_q;
				if (rdata_q == OP_NOP) begin
					finishing = 1'b1;
					nxt_pc    = pc_p1;
					step      = 2'd1;
				end else if (rdata_q == OP_LD_BC || rdata_q == OP_LD_DE ||
						rdata_q == OP_LD_HL || rdata_q == OP_LD_SP) begin
					rd_en     = 1'b1;
					rd_addr   = pc_p1[ADDR_BITS-1:0];
					nxt_state = S_IMM1;
				end else if (rdata_q == OP_ST_BC || rdata_q == OP_ST_DE ||
						rdata_q == OP_ST_HLI || rdata_q == OP_ST_HLD) begin
					finishing = 1'b1;
					wr_en     = fin;
					wr_data   = acc_q;
					nxt_pc    = pc_p1;
					step      = 2'd2;
					if (rdata_q == OP_ST_BC) begin
						wr_addr = bc[ADDR_BITS-1:0];
					end else if (rdata_q == OP_ST_DE) begin
						wr_addr = de[ADDR_BITS-1:0];
					end else begin
						wr_addr = hl[ADDR_BITS-1:0];
						if (rdata_q == OP_ST_HLI) begin
							{nxt_h, nxt_l} = hl + 16'd1;
						end else begin
							{nxt_h, nxt_l} = hl - 16'd1;
						end
					end
				end else if (rdata_q[7:3] == GRP_ADC && rdata_q[2:0] != SEL_HL) begin
					finishing        = 1'b1;
					nxt_acc          = sum9[7:0];
					nxt_flags        = 4'h0;
					nxt_flags[FLAG_Z] = (sum9[7:0] == 8'h00);
					nxt_flags[FLAG_H] = half5[4];
					nxt_flags[FLAG_C] = sum9[8];
					nxt_pc           = pc_p1;
					step             = 2'd1;
				end else if (rdata_q[7:3] == GRP_XOR && rdata_q[2:0] != SEL_HL) begin
					finishing        = 1'b1;
					nxt_acc          = xor_res;
					nxt_flags        = 4'h0;
					nxt_flags[FLAG_Z] = (xor_res == 8'h00);
					nxt_pc           = pc_p1;
					step             = 2'd1;
				end else if (rdata_q == OP_PREFIX) begin
					rd_en     = 1'b1;
					rd_addr   = pc_p1[ADDR_BITS-1:0];
					nxt_state = S_CB;
				end else begin
					finishing  = 1'b1;
					nxt_halted = 1'b1;
				end
			end
			S_IMM1: begin
				seen      = op_q;
				rd_en     = 1'b1;
				rd_addr   = pc_p2[ADDR_BITS-1:0];
				nxt_state = S_IMM2;
			end
			S_IMM2: begin
				seen      = op_q;
				finishing = 1'b1;
				nxt_pc    = pc_q + 16'd3;
				step      = 2'd3;
				if (op_q == OP_LD_BC) begin
					nxt_b = rdata_q;
					nxt_c = lo_q;
				end else if (op_q == OP_LD_DE) begin
					nxt_d = rdata_q;
					nxt_e = lo_q;
				end else if (op_q == OP_LD_HL) begin
					nxt_h = rdata_q;
					nxt_l = lo_q;
				end else begin
					nxt_sp = {rdata_q, lo_q};
				end
			end
			S_CB: begin
				seen      = op_q;
				finishing = 1'b1;
				if (rdata_q[7:6] == GRP_BIT && rdata_q[2:0] != SEL_HL) begin
					nxt_flags[FLAG_Z] = !rval[rdata_q[5:3]];
					nxt_flags[FLAG_N] = 1'b0;
					nxt_flags[FLAG_H] = 1'b1;
					nxt_pc            = pc_p2;
					step              = 2'd2;
				end else begin
					nxt_halted = 1'b1;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase

		if (finishing) begin
			nxt_state = fin ? S_IDLE : state_q;
		end
	end

	// Program memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			ld_addr_q <= req.load_address;
			ld_data_q <= req.load_data;
		end
		if (state_q == S_OP) begin
			op_q <= rdata_q;
		end
		if (state_q == S_IMM1) begin
			lo_q <= rdata_q;
		end
		if (fin) begin
			rsp_q.pc_out       <= nxt_pc;
			rsp_q.acc_out      <= nxt_acc;
			rsp_q.flags_out    <= nxt_flags;
			rsp_q.bc_out       <= {nxt_b, nxt_c};
			rsp_q.de_out       <= {nxt_d, nxt_e};
			rsp_q.hl_out       <= {nxt_h, nxt_l};
			rsp_q.sp_out       <= nxt_sp;
			rsp_q.step_cycles  <= step;
			rsp_q.cycles_total <= cyc_q + {30'd0, step};
			rsp_q.halted_out   <= nxt_halted;
			rsp_q.opcode_seen  <= seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= 16'h0000;
			sp_q        <= 16'h0000;
			acc_q       <= 8'h00;
			b_q         <= 8'h00;
			c_q         <= 8'h00;
			d_q         <= 8'h00;
			e_q         <= 8'h00;
			h_q         <= 8'h00;
			l_q         <= 8'h00;
			flags_q     <= 4'h0;
			cyc_q       <= 32'd0;
			halted_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (fin) begin
				pc_q     <= nxt_pc;
				sp_q     <= nxt_sp;
				acc_q    <= nxt_acc;
				b_q      <= nxt_b;
				c_q      <= nxt_c;
				d_q      <= nxt_d;
				e_q      <= nxt_e;
				h_q      <= nxt_h;
				l_q      <= nxt_l;
				flags_q  <= nxt_flags;
				cyc_q    <= cyc_q + {30'd0, step};
				halted_q <= nxt_halted;
			end
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/sv/eight_bit_cpu_subset_core_tb.sv =====
// Testbench for eight_bit_cpu_subset_core: loads programs through memory-write items, steps
// them one instruction at a time and checks every result against an in-bench CPU model.
// Depends on ebcpu_pkg and the core RTL.
module eight_bit_cpu_subset_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ebcpu_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	// Architectural state of the CPU as the bench expects it.
	logic [7:0]  cpu_a = '0, cpu_b = '0, cpu_c = '0, cpu_d = '0, cpu_e = '0, cpu_h = '0;
	logic [7:0]  cpu_l = '0;
	logic [3:0]  cpu_f = '0;
	logic [15:0] cpu_pc = '0, cpu_sp = '0;
	logic [31:0] cpu_cycles = '0;
	logic        cpu_halted = 1'b0;
	logic [7:0]  mem_img [MEM_DEPTH];
	bit          mem_known [MEM_DEPTH];

	rsp_item_t expected_q [$];

	int errors = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int n_writes = 0, n_steps = 0, n_nop = 0, n_ldimm = 0, n_store = 0;
	int n_adc = 0, n_xor = 0, n_bit = 0, pc_wraps = 0;

	eight_bit_cpu_subset_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] mem_peek(input logic [15:0] addr);
		return mem_img[mem_addr_t'(addr)];
	endfunction

	function automatic void mem_poke(input logic [15:0] addr, input logic [7:0] data);
		mem_img[mem_addr_t'(addr)] = data;
		mem_known[mem_addr_t'(addr)] = 1'b1;
	endfunction

	function automatic logic [7:0] reg_sel(input logic [2:0] sel);
		case (sel)
			SEL_B: return cpu_b;
			SEL_C: return cpu_c;
			SEL_D: return cpu_d;
			SEL_E: return cpu_e;
			SEL_H: return cpu_h;
			SEL_L: return cpu_l;
			SEL_A: return cpu_a;
			default: return 8'h00;
		endcase
	endfunction

	function automatic bit op_known(input logic [7:0] op, input logic [7:0] sub);
		case (op)
			OP_NOP, OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP,
			OP_ST_BC, OP_ST_DE, OP_ST_HLI, OP_ST_HLD: return 1'b1;
			OP_PREFIX: return sub[7:6] == GRP_BIT && sub[2:0] != SEL_HL;
			default: return (op[7:3] == GRP_ADC || op[7:3] == GRP_XOR) && op[2:0] != SEL_HL;
		endcase
	endfunction

	// Applies one accepted item to the expected CPU state and returns the result it causes.
	function automatic rsp_item_t cpu_execute(input req_item_t item);
		logic [7:0]  op, sub, opnd;
		logic [15:0] imm, ptr, pc_step, next_pc;
		logic [8:0]  sum;
		logic [4:0]  half;
		logic [1:0]  steps;
		rsp_item_t   res;
		steps = 2'd0;
		pc_step = 16'd0;
		op = 8'h00;
		if (item.mode) begin
			mem_poke(item.load_address, item.load_data);
			n_writes++;
		end else if (!cpu_halted) begin
			n_steps++;
			op = mem_peek(cpu_pc);
			sub = mem_peek(cpu_pc + 16'd1);
			imm = {mem_peek(cpu_pc + 16'd2), sub};
			opnd = reg_sel(op[2:0]);
			case (op)
				OP_NOP: begin
					steps = 2'd1;
					pc_step = 16'd1;
					n_nop++;
				end
				OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP: begin
					case (op)
						OP_LD_BC: {cpu_b, cpu_c} = imm;
						OP_LD_DE: {cpu_d, cpu_e} = imm;
						OP_LD_HL: {cpu_h, cpu_l} = imm;
						default: cpu_sp = imm;
					endcase
					steps = 2'd3;
					pc_step = 16'd3;
					n_ldimm++;
				end
				OP_ST_BC, OP_ST_DE, OP_ST_HLI, OP_ST_HLD: begin
					case (op)
						OP_ST_BC: ptr = {cpu_b, cpu_c};
						OP_ST_DE: ptr = {cpu_d, cpu_e};
						default: ptr = {cpu_h, cpu_l};
					endcase
					mem_poke(ptr, cpu_a);
					if (op == OP_ST_HLI)
						{cpu_h, cpu_l} = ptr + 16'd1;
					else if (op == OP_ST_HLD)
						{cpu_h, cpu_l} = ptr - 16'd1;
					steps = 2'd2;
					pc_step = 16'd1;
					n_store++;
				end
				default: begin
					if (!op_known(op, sub)) begin
						cpu_halted = 1'b1;
					end else if (op == OP_PREFIX) begin
						opnd = reg_sel(sub[2:0]);
						// The carry flag survives a bit test.
						cpu_f[FLAG_Z] = ~opnd[sub[5:3]];
						cpu_f[FLAG_N] = 1'b0;
						cpu_f[FLAG_H] = 1'b1;
						steps = 2'd2;
						pc_step = 16'd2;
						n_bit++;
					end else if (op[7:3] == GRP_ADC) begin
						sum = {1'b0, cpu_a} + {1'b0, opnd} + {8'h00, cpu_f[FLAG_C]};
						half = {1'b0, cpu_a[3:0]} + {1'b0, opnd[3:0]} + {4'h0, cpu_f[FLAG_C]};
						cpu_a = sum[7:0];
						cpu_f = '0;
						cpu_f[FLAG_Z] = sum[7:0] == 8'h00;
						cpu_f[FLAG_H] = half[4];
						cpu_f[FLAG_C] = sum[8];
						steps = 2'd1;
						pc_step = 16'd1;
						n_adc++;
					end else begin
						cpu_a = cpu_a ^ opnd;
						cpu_f = '0;
						cpu_f[FLAG_Z] = cpu_a == 8'h00;
						steps = 2'd1;
						pc_step = 16'd1;
						n_xor++;
					end
				end
			endcase
			next_pc = cpu_pc + pc_step;
			if (next_pc < cpu_pc)
				pc_wraps++;
			cpu_pc = next_pc;
			cpu_cycles = cpu_cycles + 32'(steps);
		end
		res.pc_out = cpu_pc;
		res.acc_out = cpu_a;
		res.flags_out = cpu_f;
		res.bc_out = {cpu_b, cpu_c};
		res.de_out = {cpu_d, cpu_e};
		res.hl_out = {cpu_h, cpu_l};
		res.sp_out = cpu_sp;
		res.step_cycles = steps;
		res.cycles_total = cpu_cycles;
		res.halted_out = cpu_halted;
		res.opcode_seen = op;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(input rsp_item_t want, input rsp_item_t got);
		check_field("pc_out", 32'(want.pc_out), 32'(got.pc_out));
		check_field("acc_out", 32'(want.acc_out), 32'(got.acc_out));
		check_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
		check_field("bc_out", 32'(want.bc_out), 32'(got.bc_out));
		check_field("de_out", 32'(want.de_out), 32'(got.de_out));
		check_field("hl_out", 32'(want.hl_out), 32'(got.hl_out));
		check_field("sp_out", 32'(want.sp_out), 32'(got.sp_out));
		check_field("step_cycles", 32'(want.step_cycles), 32'(got.step_cycles));
		check_field("cycles_total", want.cycles_total, got.cycles_total);
		check_field("halted_out", 32'(want.halted_out), 32'(got.halted_out));
		check_field("opcode_seen", 32'(want.opcode_seen), 32'(got.opcode_seen));
	endtask

	// Handshakes are judged at the falling edge, where every signal is settled for the
	// rising edge that follows.
	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				$error("result item arrived with no expected result pending");
				errors++;
			end else begin
				check_result(expected_q.pop_front(), rsp);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
			$display("eight_bit_cpu_subset_core: mismatch");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_ready <= $urandom_range(99) >= stall_pct;

	// Called at a rising edge; returns at the rising edge where the item was accepted.
	task automatic send_item(input req_item_t item);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		items_sent++;
		expected_q.push_back(cpu_execute(item));
	endtask

	task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
		req_item_t item;
		item.mode = 1'b1;
		item.load_address = addr;
		item.load_data = data;
		send_item(item);
	endtask

	// Executes the instruction at the program counter. Bytes the fetch could touch are
	// filled first so that no step executes from unwritten memory.
	task automatic step_cpu();
		req_item_t item;
		if (!cpu_halted)
			for (int k = 0; k < 3; k++)
				if (!mem_known[mem_addr_t'(cpu_pc + 16'(k))])
					write_byte(cpu_pc + 16'(k), 8'($urandom));
		item.mode = 1'b0;
		item.load_address = 16'($urandom);
		item.load_data = 8'($urandom);
		send_item(item);
	endtask

	task automatic put_instr(input logic [7:0] b0, b1, b2, input int len);
		logic [15:0] at;
		at = cpu_pc;
		write_byte(at, b0);
		if (len > 1)
			write_byte(at + 16'd1, b1);
		if (len > 2)
			write_byte(at + 16'd2, b2);
		step_cpu();
	endtask

	// Re-executes whatever already sits at the program counter, if it will not halt.
	task automatic replay_step();
		logic [15:0] at;
		at = cpu_pc;
		if (mem_known[mem_addr_t'(at)] && mem_known[mem_addr_t'(at + 16'd1)]
				&& mem_known[mem_addr_t'(at + 16'd2)]
				&& op_known(mem_peek(at), mem_peek(at + 16'd1)))
			step_cpu();
	endtask

	function automatic logic [2:0] pick_reg();
		logic [2:0] sel;
		do sel = 3'($urandom_range(7)); while (sel == SEL_HL);
		return sel;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_instr();
		logic [15:0] word;
		logic [7:0]  op;
		int          roll;
		word = pick_word();
		roll = $urandom_range(99);
		if (roll < 20) begin
			case ($urandom_range(3))
				0: op = OP_LD_BC;
				1: op = OP_LD_DE;
				2: op = OP_LD_HL;
				default: op = OP_LD_SP;
			endcase
			put_instr(op, word[7:0], word[15:8], 3);
		end else if (roll < 35) begin
			case ($urandom_range(3))
				0: op = OP_ST_BC;
				1: op = OP_ST_DE;
				2: op = OP_ST_HLI;
				default: op = OP_ST_HLD;
			endcase
			put_instr(op, 8'h00, 8'h00, 1);
		end else if (roll < 58) begin
			put_instr({GRP_ADC, pick_reg()}, 8'h00, 8'h00, 1);
		end else if (roll < 78) begin
			put_instr({GRP_XOR, pick_reg()}, 8'h00, 8'h00, 1);
		end else if (roll < 95) begin
			put_instr(OP_PREFIX, {GRP_BIT, 3'($urandom_range(7)), pick_reg()}, 8'h00, 2);
		end else begin
			put_instr(OP_NOP, 8'h00, 8'h00, 1);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	// A hand-built program: immediate byte order, pair wrap on both pointer stores,
	// half and full carry, carry-in, bit test set and clear, and a zero result.
	task automatic test_directed_program();
		logic [7:0] prog [$];
		prog = '{OP_LD_BC, 8'h34, 8'h12, OP_LD_HL, 8'hff, 8'hff, {GRP_XOR, SEL_B},
			OP_ST_HLI, OP_ST_HLD, {GRP_ADC, SEL_H}, {GRP_ADC, SEL_A},
			OP_PREFIX, {GRP_BIT, 3'd7, SEL_H}, OP_PREFIX, {GRP_BIT, 3'd0, SEL_B},
			{GRP_XOR, SEL_A}, OP_NOP};
		gap_pct = 0;
		stall_pct = 0;
		write_byte(16'hffff, 8'hff);
		foreach (prog[k])
			write_byte(16'(k), prog[k]);
		repeat (11)
			step_cpu();
		drain();
	endtask

	task automatic test_random_program(input int count, input int gap, input int stall);
		int stop;
		int roll;
		gap_pct = gap;
		stall_pct = stall;
		stop = items_sent + count;
		while (items_sent < stop) begin
			roll = $urandom_range(99);
			if (roll < 10)
				write_byte(16'($urandom), 8'($urandom));
			else if (roll < 16)
				replay_step();
			else
				random_instr();
		end
		drain();
	endtask

	// An unknown opcode stops the core for good; later steps change nothing while
	// memory writes still land.
	task automatic test_halt();
		logic [7:0] op, sub;
		gap_pct = 12;
		stall_pct = 12;
		if ($urandom_range(1)) begin
			do sub = 8'($urandom); while (op_known(OP_PREFIX, sub));
			put_instr(OP_PREFIX, sub, 8'h00, 2);
		end else begin
			do op = 8'($urandom); while (op_known(op, 8'h00) || op == OP_PREFIX);
			put_instr(op, 8'h00, 8'h00, 1);
		end
		write_byte(cpu_pc, OP_NOP);
		repeat (6) begin
			step_cpu();
			write_byte(16'($urandom), 8'($urandom));
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_program();
		test_random_program(200, 0, 0);
		test_random_program(200, 45, 0);
		test_random_program(200, 0, 45);
		test_random_program(200, 12, 12);
		test_halt();
		repeat (8) @(posedge clk);
		$display("executed %0d steps: %0d loads, %0d stores, %0d ADC, %0d XOR, %0d BIT, %0d NOP",
			n_steps, n_ldimm, n_store, n_adc, n_xor, n_bit, n_nop);
		$display("%0d memory writes, program counter wrapped %0d time(s), halted at end: %0b",
			n_writes, pc_wraps, cpu_halted);
		if (errors == 0)
			$display("eight_bit_cpu_subset_core: match");
		else
			$display("eight_bit_cpu_subset_core: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
design/ebcpu_pkg.sv
design/eight_bit_cpu_subset_core.sv
tb/sv/eight_bit_cpu_subset_core_tb.sv
